/* design/atrr_pkg.sv */
package atrr_pkg;

    localparam int PRICE_W     = 32;
    localparam int AVG_W       = 48;
    localparam int NUM_W       = 56;
    localparam int PERIOD_W    = 8;
    localparam int COUNT_W     = 9;
    localparam int RATIO_W     = 24;
    localparam int DIV_CNT_W   = 6;

    localparam logic [PERIOD_W-1:0]  PERIOD_RESET = 8'd14;
    localparam logic [RATIO_W-1:0]   RATIO_MAX    = 24'hFF_FFFF;
    localparam logic [DIV_CNT_W-1:0] ITERS_AVG    = 6'd48;
    localparam logic [DIV_CNT_W-1:0] ITERS_RATIO  = 6'd24;

    // request to the shared serial divider
    typedef struct packed {
        logic                  start;
        logic [DIV_CNT_W-1:0]  iters;
        logic [PRICE_W-1:0]    rem_init;
        logic [AVG_W-1:0]      dvd;
        logic [PRICE_W-1:0]    dvs;
    } t_div_req;

    typedef struct packed {
        logic              busy;
        logic [AVG_W-1:0]  quo;
    } t_div_stat;

endpackage

/* design/atrr_div.sv */
module atrr_div
    import atrr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_div_req  i_req,
    output t_div_stat o_stat
);

    logic [DIV_CNT_W-1:0] r_cnt;
    logic [PRICE_W-1:0]   r_rem;
    logic [AVG_W-1:0]     r_sh;
    logic [PRICE_W-1:0]   r_dvs;

    logic [PRICE_W+1:0]   w_diff;
    logic                 w_qbit;
    logic [PRICE_W-1:0]   n_rem;

    // restoring step, one quotient bit per cycle
    always_comb begin
        w_diff = {1'b0, r_rem, r_sh[AVG_W-1]} - {2'b00, r_dvs};
        w_qbit = ~w_diff[PRICE_W+1];
        n_rem  = w_qbit ? w_diff[PRICE_W-1:0] : {r_rem[PRICE_W-2:0], r_sh[AVG_W-1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_req.start) begin
            r_cnt <= i_req.iters;
            r_rem <= i_req.rem_init;
            r_sh  <= i_req.dvd;
            r_dvs <= i_req.dvs;
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
            r_rem <= n_rem;
            r_sh  <= {r_sh[AVG_W-2:0], w_qbit};
        end
    end

    assign o_stat.busy = (r_cnt != '0);
    assign o_stat.quo  = r_sh;

endmodule

/* design/average_true_range_ratio_core.sv */
// channel  | direction | request moves
// cfg      | in        | smoothing period, 8 bits
// s        | in        | price bar: high, low, close, start-of-series flag
// m        | out       | smoothed true range and range/close ratio
//
// a continuing bar passes through these steps in order: true range,
// one 48x8 multiply-add, a 48-bit serial division (one bit per cycle) and a 24-bit
// serial division for the ratio, both on the one shared divider; the result then
// moves from S_DONE into the output register
// a start-of-series bar goes straight to S_DONE; a saturated or zero-close ratio
// skips the second division
// synchronous active-low reset clears the average, count and last close and sets period 14
// the output register lets a new bar be taken while a result waits on i_m_tready;
// a finished bar waits in its last state until that register frees
module average_true_range_ratio_core
    import atrr_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [PERIOD_W-1:0] i_cfg_data,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [95:0]         i_s_tdata,   // bar_high, bar_low, bar_close
    input  logic                i_s_tuser,   // series_start
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [55:0]         o_m_tdata    // range_average, range_ratio
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_TR,
        S_MUL,
        S_DIV1,
        S_WAIT1,
        S_RATIO,
        S_WAIT2,
        S_DONE
    } t_state;

    t_state               r_state, n_state;
    logic [PERIOD_W-1:0]  r_period;
    logic [PRICE_W-1:0]   r_last_close, n_last_close;
    logic [AVG_W-1:0]     r_sr, n_sr;
    logic [COUNT_W-1:0]   r_count, n_count;
    logic [PRICE_W-1:0]   r_hi, r_lo, r_cl;
    logic [PRICE_W-1:0]   r_tr, n_tr;
    logic [PERIOD_W-1:0]  r_mul, n_mul, r_dvs, n_dvs;
    logic [NUM_W-1:0]     r_num, n_num;
    logic [RATIO_W-1:0]   r_ratio, n_ratio;
    logic                 r_out_valid, n_out_valid;
    logic [PRICE_W-1:0]   r_out_avg, n_out_avg;
    logic [RATIO_W-1:0]   r_out_ratio, n_out_ratio;

    logic [PRICE_W:0]     w_hp, w_lp, w_hl;
    logic [PRICE_W-1:0]   w_abs_hp, w_abs_lp, w_best;
    logic [PERIOD_W-1:0]  w_pe;
    logic [COUNT_W-1:0]   w_cnt1, w_pe1, w_idx;
    logic [NUM_W-1:0]     w_prod;
    logic                 w_accept, w_start;

    t_div_req             div_req;
    t_div_stat            div_stat;

    atrr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_stat  (div_stat)
    );

    assign w_accept = i_s_tvalid && o_s_tready;

    // true range against the previous close
    always_comb begin
        w_hp     = {1'b0, r_hi} - {1'b0, r_last_close};
        w_lp     = {1'b0, r_lo} - {1'b0, r_last_close};
        w_hl     = {1'b0, r_hi} - {1'b0, r_lo};
        w_abs_hp = w_hp[PRICE_W] ? (r_last_close - r_hi) : w_hp[PRICE_W-1:0];
        w_abs_lp = w_lp[PRICE_W] ? (r_last_close - r_lo) : w_lp[PRICE_W-1:0];
        w_best   = (w_abs_lp > w_abs_hp) ? w_abs_lp : w_abs_hp;
        if (!w_hl[PRICE_W] && (w_hl[PRICE_W-1:0] > w_best)) begin
            w_best = w_hl[PRICE_W-1:0];
        end
    end

    // bar index and divisor selection
    always_comb begin
        w_pe   = (r_period == '0) ? PERIOD_W'(1) : r_period;
        w_cnt1 = r_count + 1'b1;
        w_pe1  = {1'b0, w_pe} + 1'b1;
        w_idx  = (w_cnt1 > w_pe1) ? w_pe1 : w_cnt1;
    end

    assign w_prod = r_sr * r_mul;

    always_comb begin
        n_state      = r_state;
        n_last_close = r_last_close;
        n_sr         = r_sr;
        n_count      = r_count;
        n_tr         = r_tr;
        n_mul        = r_mul;
        n_dvs        = r_dvs;
        n_num        = r_num;
        n_ratio      = r_ratio;
        n_out_valid  = r_out_valid && !i_m_tready;
        n_out_avg    = r_out_avg;
        n_out_ratio  = r_out_ratio;
        w_start      = 1'b0;
        div_req      = '0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_s_tuser) begin
                        n_sr         = '0;
                        n_count      = '0;
                        n_last_close = i_s_tdata[95:64];
                        n_ratio      = '0;
                        n_state      = S_DONE;
                    end else begin
                        n_state = S_TR;
                    end
                end
            end
            S_TR: begin
                n_tr         = w_best;
                n_count      = w_idx;
                n_last_close = r_cl;
                if (w_idx <= {1'b0, w_pe}) begin
                    n_dvs = w_idx[PERIOD_W-1:0];
                    n_mul = w_idx[PERIOD_W-1:0] - 1'b1;
                end else begin
                    n_dvs = w_pe;
                    n_mul = w_pe - 1'b1;
                end
                n_state = S_MUL;
            end
            S_MUL: begin
                n_num   = w_prod + {8'b0, r_tr, 16'b0};
                n_state = S_DIV1;
            end
            S_DIV1: begin
                w_start          = 1'b1;
                div_req.start    = 1'b1;
                div_req.iters    = ITERS_AVG;
                div_req.rem_init = {24'b0, r_num[NUM_W-1:AVG_W]};
                div_req.dvd      = r_num[AVG_W-1:0];
                div_req.dvs      = {24'b0, r_dvs};
                n_state          = S_WAIT1;
            end
            S_WAIT1: begin
                if (!div_stat.busy) begin
                    n_sr    = div_stat.quo;
                    n_state = S_RATIO;
                end
            end
            S_RATIO: begin
                if (r_cl == '0) begin
                    n_ratio = '0;
                    n_state = S_DONE;
                end else if (r_sr[AVG_W-1:16] >= r_cl) begin
                    n_ratio = RATIO_MAX;
                    n_state = S_DONE;
                end else begin
                    w_start          = 1'b1;
                    div_req.start    = 1'b1;
                    div_req.iters    = ITERS_RATIO;
                    div_req.rem_init = r_sr[AVG_W-1:16];
                    div_req.dvd      = {r_sr[15:0], 32'b0};
                    div_req.dvs      = r_cl;
                    n_state          = S_WAIT2;
                end
            end
            S_WAIT2: begin
                if (!div_stat.busy) begin
                    n_ratio = div_stat.quo[RATIO_W-1:0];
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_avg   = r_sr[AVG_W-1:16];
                    n_out_ratio = r_ratio;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_period     <= PERIOD_RESET;
            r_last_close <= '0;
            r_sr         <= '0;
            r_count      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_last_close <= n_last_close;
            r_sr         <= n_sr;
            r_count      <= n_count;
            r_out_valid  <= n_out_valid;
            if (i_cfg_valid) begin
                r_period <= i_cfg_data;
            end
        end
        if (w_accept) begin
            r_hi <= i_s_tdata[31:0];
            r_lo <= i_s_tdata[63:32];
            r_cl <= i_s_tdata[95:64];
        end
        r_tr        <= n_tr;
        r_mul       <= n_mul;
        r_dvs       <= n_dvs;
        r_num       <= n_num;
        r_ratio     <= n_ratio;
        r_out_avg   <= n_out_avg;
        r_out_ratio <= n_out_ratio;
    end

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == S_IDLE);
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = {r_out_ratio, r_out_avg};

    a_idle_div_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !div_stat.busy)
        else $error("divider busy while idle");

    a_start_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |-> !div_stat.busy)
        else $error("divider restarted while busy");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != S_IDLE))
        else $error("bar accepted without leaving idle");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> (r_count <= {1'b0, w_pe} + 1'b1))
        else $error("bar count beyond period plus one");

endmodule
